[src/imu_sc_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and fixed-point helpers for the IMU sample correction block.
// Depends on nothing; every other file imports it.
package imu_sc_pkg;

    // Store geometry and number format
    localparam int NUM_UNITS      = 8;
    localparam int FRAC_BITS      = 16;
    localparam int COEFS_PER_UNIT = 31;
    localparam int COEF_IX_W      = 5;
    localparam int UNIT_W         = 3;
    localparam int UNIT_AW        = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
    localparam int UNIT_IX_W      = (UNIT_AW > UNIT_W) ? UNIT_AW : UNIT_W;
    localparam int MASK_W         = 8;
    localparam int WORD_W         = 32;
    localparam int PROD_W         = 64;
    localparam int SUM_W          = 66;
    localparam int NUM_AXES       = 3;
    localparam int NUM_SOFT       = 9;
    localparam int NUM_STAGES     = 6;

    // Word layout within one unit
    localparam int IX_ACC_OFF = 0;
    localparam int IX_ACC_SCL = 3;
    localparam int IX_GYR_OFF = 6;
    localparam int IX_GYR_SCL = 9;
    localparam int IX_MAG_OFF = 12;
    localparam int IX_SOFT    = 15;
    localparam int IX_TREF    = 24;
    localparam int IX_TC_ACC  = 25;
    localparam int IX_TC_GYR  = 28;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    typedef logic [COEFS_PER_UNIT-1:0][WORD_W-1:0] coef_row_t;
    typedef logic [COEFS_PER_UNIT-1:0]             coef_valid_t;

    typedef enum logic [1:0] {
        KIND_ACC  = 2'd0,
        KIND_GYR  = 2'd1,
        KIND_MAG  = 2'd2,
        KIND_NONE = 2'd3
    } kind_t;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_COEF   = 1'b1
    } op_t;

    // Per-stage load enables and the output valid
    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
        logic                  out_valid;
    } pipe_ctrl_t;

    localparam word_t Q_ONE    = word_t'(1 << FRAC_BITS);
    localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    // Clamp a wide signed value to the 32-bit range
    function automatic word_t sat_sum(input sum_t v);
        word_t r;
        if ((&v[SUM_W-1:WORD_W-1]) || !(|v[SUM_W-1:WORD_W-1])) begin
            r = v[WORD_W-1:0];
        end else if (v[SUM_W-1]) begin
            r = WORD_MIN;
        end else begin
            r = WORD_MAX;
        end
        return r;
    endfunction

    // Saturating a - b
    function automatic word_t sub_sat(input word_t a, input word_t b);
        logic [WORD_W:0] d;
        d = {a[WORD_W-1], a} - {b[WORD_W-1], b};
        return sat_sum({{(SUM_W-WORD_W-1){d[WORD_W]}}, d});
    endfunction

    // Floor a product down by the fraction bits, then saturate
    function automatic word_t shift_sat(input prod_t p);
        prod_t s;
        s = p >>> FRAC_BITS;
        return sat_sum({{(SUM_W-PROD_W){s[PROD_W-1]}}, s});
    endfunction

    // Floor an exact sum of products down by the fraction bits, then saturate
    function automatic word_t sum_shift_sat(input sum_t v);
        sum_t s;
        s = v >>> FRAC_BITS;
        return sat_sum(s);
    endfunction

    // Value of a coefficient that was never written: unity scales, identity matrix
    function automatic word_t coef_reset(input int idx);
        word_t r;
        if ((idx >= IX_ACC_SCL && idx < IX_ACC_SCL + NUM_AXES) ||
            (idx >= IX_GYR_SCL && idx < IX_GYR_SCL + NUM_AXES) ||
            idx == IX_SOFT || idx == IX_SOFT + 4 || idx == IX_SOFT + 8) begin
            r = Q_ONE;
        end else begin
            r = '0;
        end
        return r;
    endfunction

endpackage

[src/imu_sample_correction.sv]
`timescale 1ns / 1ps
// IMU sample correction, top level.
// Input channel (in_valid/in_ready) carries one request per handshake: op selects a sample
// correction or a coefficient write into the per-unit store. A sample request yields one
// result on the output channel (out_valid/out_ready); a coefficient write yields none and
// is visible to any sample request accepted after it.
// cfg_wen/cfg_wdata write active_unit_mask; a clear bit returns samples uncorrected with
// passed_through set. Write it only while no request is in flight.
// Throughput: one request per cycle while out_ready stays high. A result passes through
// six register stages (store read, coefficient select, multiply, saturate/sum, multiply,
// output select); the first loads at the accepting edge.
// Each stage holds its own valid bit, so when out_ready stays low the output holds and
// empty stages upstream still fill; in_ready drops only once every stage is occupied.
// Reset clears all valid bits, the mask and the store's written flags, so every unit reads
// unity scales, identity soft-iron matrix and zero elsewhere until rewritten.
// Depends on imu_sc_pkg, imu_sc_coef_store, imu_sc_pipe_ctrl, imu_sc_datapath.
module imu_sample_correction
    import imu_sc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wen,
    input  logic [MASK_W-1:0]    cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 op,
    input  logic [1:0]           sensor_kind,
    input  logic [UNIT_W-1:0]    unit,
    input  logic signed [31:0]   raw_x,
    input  logic signed [31:0]   raw_y,
    input  logic signed [31:0]   raw_z,
    input  logic signed [31:0]   temperature,
    input  logic [COEF_IX_W-1:0] coef_index,
    input  logic signed [31:0]   coef_value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [31:0]   cal_x,
    output logic signed [31:0]   cal_y,
    output logic signed [31:0]   cal_z,
    output logic                 passed_through
);

    logic [MASK_W-1:0] mask_reg;
    pipe_ctrl_t        ctrl;
    kind_t             kind;
    logic              accept;
    logic              coef_req;
    logic              load_sample;
    logic              pass;
    coef_row_t         rd_coef;

    // Hold the unit mask
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else if (cfg_wen)
        begin
            mask_reg <= cfg_wdata;
        end
    end

    // Decode the request
    assign kind        = kind_t'(sensor_kind);
    assign in_ready    = ctrl.en[0];
    assign accept      = in_valid && in_ready;
    assign coef_req    = accept && (op == OP_COEF);
    assign load_sample = in_valid && (op == OP_SAMPLE);
    assign pass        = !(int'(unit) < NUM_UNITS) || !mask_reg[unit] || (kind == KIND_NONE);
    assign out_valid   = ctrl.out_valid;

    imu_sc_pipe_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_sample (load_sample),
        .out_ready   (out_ready),
        .ctrl        (ctrl)
    );

    imu_sc_coef_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_req   (coef_req),
        .wr_unit  (unit),
        .wr_index (coef_index),
        .wr_data  (coef_value),
        .rd_en    (ctrl.en[0]),
        .rd_unit  (unit),
        .rd_coef  (rd_coef)
    );

    imu_sc_datapath u_dp (
        .clk            (clk),
        .ctrl           (ctrl),
        .kind           (kind),
        .pass           (pass),
        .raw_x          (raw_x),
        .raw_y          (raw_y),
        .raw_z          (raw_z),
        .temperature    (temperature),
        .rd_coef        (rd_coef),
        .cal_x          (cal_x),
        .cal_y          (cal_y),
        .cal_z          (cal_z),
        .passed_through (passed_through)
    );

endmodule

[src/imu_sc_coef_store.sv]
`timescale 1ns / 1ps
// Coefficient store: one row of 31 words per unit, word-enabled writes, registered row read.
// Per-word valid bits substitute the reset coefficients. Depends on imu_sc_pkg.
module imu_sc_coef_store
    import imu_sc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_req,
    input  logic [UNIT_W-1:0]    wr_unit,
    input  logic [COEF_IX_W-1:0] wr_index,
    input  word_t                wr_data,
    input  logic                 rd_en,
    input  logic [UNIT_W-1:0]    rd_unit,
    output coef_row_t            rd_coef
);

    logic [UNIT_IX_W-1:0] wr_unit_x;
    logic [UNIT_IX_W-1:0] rd_unit_x;
    logic [UNIT_AW-1:0]   wr_addr;
    logic [UNIT_AW-1:0]   rd_addr;
    logic                 wr_hit;

    coef_row_t                                mem [NUM_UNITS];
    coef_row_t                                row_reg;
    coef_valid_t                              vrow_reg;
    logic [NUM_UNITS-1:0][COEFS_PER_UNIT-1:0] valid_reg;

    // Address decode; drop writes to missing units or indexes
    assign wr_unit_x = UNIT_IX_W'(wr_unit);
    assign rd_unit_x = UNIT_IX_W'(rd_unit);
    assign wr_addr   = wr_unit_x[UNIT_AW-1:0];
    assign rd_addr   = rd_unit_x[UNIT_AW-1:0];
    assign wr_hit    = wr_req && (int'(wr_unit) < NUM_UNITS)
                       && (int'(wr_index) < COEFS_PER_UNIT);

    // Write one word, read one row
    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            mem[wr_addr][wr_index] <= wr_data;
        end
        if (rd_en)
        begin
            row_reg <= mem[rd_addr];
        end
    end

    // Track which words have been written since reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            vrow_reg  <= '0;
        end
        else
        begin
            if (wr_hit)
            begin
                valid_reg[wr_addr][wr_index] <= 1'b1;
            end
            if (rd_en)
            begin
                vrow_reg <= valid_reg[rd_addr];
            end
        end
    end

    // Substitute reset values for unwritten words
    always_comb
    begin
        for (int k = 0; k < COEFS_PER_UNIT; k++)
        begin
            rd_coef[k] = vrow_reg[k] ? row_reg[k] : coef_reset(k);
        end
    end

endmodule

[src/imu_sc_pipe_ctrl.sv]
`timescale 1ns / 1ps
// Pipeline control: valid bit per stage and per-stage load enables that let bubbles close up.
// Depends on imu_sc_pkg.
module imu_sc_pipe_ctrl
    import imu_sc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load_sample,
    input  logic       out_ready,
    output pipe_ctrl_t ctrl
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] en;

    // A stage loads when it is empty or its successor moves on
    always_comb
    begin
        en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
        valid_next[0] = load_sample;
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            valid_next[k] = valid_reg[k-1];
        end
    end

    // Advance valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NUM_STAGES; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_next[k];
                end
            end
        end
    end

    assign ctrl.en        = en;
    assign ctrl.out_valid = valid_reg[NUM_STAGES-1];

endmodule

[src/imu_sc_datapath.sv]
`timescale 1ns / 1ps
// Correction datapath: six register stages covering temperature, offset and scale for
// accelerometer and gyroscope, and hard/soft iron for magnetometer. Depends on imu_sc_pkg.
module imu_sc_datapath
    import imu_sc_pkg::*;
(
    input  logic       clk,
    input  pipe_ctrl_t ctrl,
    input  kind_t      kind,
    input  logic       pass,
    input  word_t      raw_x,
    input  word_t      raw_y,
    input  word_t      raw_z,
    input  word_t      temperature,
    input  coef_row_t  rd_coef,
    output word_t      cal_x,
    output word_t      cal_y,
    output word_t      cal_z,
    output logic       passed_through
);

    // Stage 1: request fields, aligned with the store read
    kind_t s1_kind_reg;
    logic  s1_pass_reg;
    word_t s1_raw_reg [NUM_AXES];
    word_t s1_temp_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.en[0])
        begin
            s1_kind_reg   <= kind;
            s1_pass_reg   <= pass;
            s1_raw_reg[0] <= raw_x;
            s1_raw_reg[1] <= raw_y;
            s1_raw_reg[2] <= raw_z;
            s1_temp_reg   <= temperature;
        end
    end

    // Stage 2: pick coefficients, temperature delta and hard-iron difference
    logic  sel_acc;
    word_t s2_dt_next;
    word_t s2_tc_next  [NUM_AXES];
    word_t s2_off_next [NUM_AXES];
    word_t s2_scl_next [NUM_AXES];
    word_t s2_md_next  [NUM_AXES];
    word_t s2_m_next   [NUM_SOFT];
    word_t s2_dt_reg;
    word_t s2_tc_reg   [NUM_AXES];
    word_t s2_off_reg  [NUM_AXES];
    word_t s2_scl_reg  [NUM_AXES];
    word_t s2_md_reg   [NUM_AXES];
    word_t s2_m_reg    [NUM_SOFT];
    word_t s2_raw_reg  [NUM_AXES];
    logic  s2_pass_reg;
    logic  s2_mag_reg;

    always_comb
    begin
        sel_acc    = (s1_kind_reg == KIND_ACC);
        s2_dt_next = sub_sat(s1_temp_reg, rd_coef[IX_TREF]);
        for (int i = 0; i < NUM_AXES; i++)
        begin
            s2_tc_next[i]  = sel_acc ? rd_coef[IX_TC_ACC+i]  : rd_coef[IX_TC_GYR+i];
            s2_off_next[i] = sel_acc ? rd_coef[IX_ACC_OFF+i] : rd_coef[IX_GYR_OFF+i];
            s2_scl_next[i] = sel_acc ? rd_coef[IX_ACC_SCL+i] : rd_coef[IX_GYR_SCL+i];
            s2_md_next[i]  = sub_sat(s1_raw_reg[i], rd_coef[IX_MAG_OFF+i]);
        end
        for (int j = 0; j < NUM_SOFT; j++)
        begin
            s2_m_next[j] = rd_coef[IX_SOFT+j];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[1])
        begin
            s2_dt_reg   <= s2_dt_next;
            s2_pass_reg <= s1_pass_reg;
            s2_mag_reg  <= (s1_kind_reg == KIND_MAG);
            for (int i = 0; i < NUM_AXES; i++)
            begin
                s2_tc_reg[i]  <= s2_tc_next[i];
                s2_off_reg[i] <= s2_off_next[i];
                s2_scl_reg[i] <= s2_scl_next[i];
                s2_md_reg[i]  <= s2_md_next[i];
                s2_raw_reg[i] <= s1_raw_reg[i];
            end
            for (int j = 0; j < NUM_SOFT; j++)
            begin
                s2_m_reg[j] <= s2_m_next[j];
            end
        end
    end

    // Stage 3: temperature products and soft-iron products
    prod_t s3_p1_next  [NUM_AXES];
    prod_t s3_pm_next  [NUM_SOFT];
    prod_t s3_p1_reg   [NUM_AXES];
    prod_t s3_pm_reg   [NUM_SOFT];
    word_t s3_off_reg  [NUM_AXES];
    word_t s3_scl_reg  [NUM_AXES];
    word_t s3_raw_reg  [NUM_AXES];
    logic  s3_pass_reg;
    logic  s3_mag_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            s3_p1_next[i] = prod_t'(s2_dt_reg) * prod_t'(s2_tc_reg[i]);
            for (int j = 0; j < NUM_AXES; j++)
            begin
                s3_pm_next[NUM_AXES*i+j] = prod_t'(s2_m_reg[NUM_AXES*i+j])
                                           * prod_t'(s2_md_reg[j]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[2])
        begin
            s3_pass_reg <= s2_pass_reg;
            s3_mag_reg  <= s2_mag_reg;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                s3_p1_reg[i]  <= s3_p1_next[i];
                s3_off_reg[i] <= s2_off_reg[i];
                s3_scl_reg[i] <= s2_scl_reg[i];
                s3_raw_reg[i] <= s2_raw_reg[i];
            end
            for (int j = 0; j < NUM_SOFT; j++)
            begin
                s3_pm_reg[j] <= s3_pm_next[j];
            end
        end
    end

    // Stage 4: apply temperature term and offset; sum soft-iron rows exactly
    word_t s4_tc_next  [NUM_AXES];
    word_t s4_o_next   [NUM_AXES];
    sum_t  s4_sum_next [NUM_AXES];
    word_t s4_o_reg    [NUM_AXES];
    sum_t  s4_sum_reg  [NUM_AXES];
    word_t s4_scl_reg  [NUM_AXES];
    word_t s4_raw_reg  [NUM_AXES];
    logic  s4_pass_reg;
    logic  s4_mag_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            s4_tc_next[i]  = sub_sat(s3_raw_reg[i], shift_sat(s3_p1_reg[i]));
            s4_o_next[i]   = sub_sat(s4_tc_next[i], s3_off_reg[i]);
            s4_sum_next[i] = sum_t'(s3_pm_reg[NUM_AXES*i])
                             + sum_t'(s3_pm_reg[NUM_AXES*i+1])
                             + sum_t'(s3_pm_reg[NUM_AXES*i+2]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[3])
        begin
            s4_pass_reg <= s3_pass_reg;
            s4_mag_reg  <= s3_mag_reg;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                s4_o_reg[i]   <= s4_o_next[i];
                s4_sum_reg[i] <= s4_sum_next[i];
                s4_scl_reg[i] <= s3_scl_reg[i];
                s4_raw_reg[i] <= s3_raw_reg[i];
            end
        end
    end

    // Stage 5: scale products; finish magnetometer rows
    prod_t s5_p2_next   [NUM_AXES];
    word_t s5_mcal_next [NUM_AXES];
    prod_t s5_p2_reg    [NUM_AXES];
    word_t s5_mcal_reg  [NUM_AXES];
    word_t s5_raw_reg   [NUM_AXES];
    logic  s5_pass_reg;
    logic  s5_mag_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            s5_p2_next[i]   = prod_t'(s4_o_reg[i]) * prod_t'(s4_scl_reg[i]);
            s5_mcal_next[i] = sum_shift_sat(s4_sum_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[4])
        begin
            s5_pass_reg <= s4_pass_reg;
            s5_mag_reg  <= s4_mag_reg;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                s5_p2_reg[i]   <= s5_p2_next[i];
                s5_mcal_reg[i] <= s5_mcal_next[i];
                s5_raw_reg[i]  <= s4_raw_reg[i];
            end
        end
    end

    // Stage 6: select raw, magnetometer or scaled result into the output register
    word_t s6_cal_next [NUM_AXES];
    word_t s6_cal_reg  [NUM_AXES];
    logic  s6_pass_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            if (s5_pass_reg)
            begin
                s6_cal_next[i] = s5_raw_reg[i];
            end
            else if (s5_mag_reg)
            begin
                s6_cal_next[i] = s5_mcal_reg[i];
            end
            else
            begin
                s6_cal_next[i] = shift_sat(s5_p2_reg[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[5])
        begin
            s6_pass_reg <= s5_pass_reg;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                s6_cal_reg[i] <= s6_cal_next[i];
            end
        end
    end

    assign cal_x          = s6_cal_reg[0];
    assign cal_y          = s6_cal_reg[1];
    assign cal_z          = s6_cal_reg[2];
    assign passed_through = s6_pass_reg;

endmodule

[test/imu_sc_checker.sv]
`timescale 1ns / 1ps
// Result checker for imu_sample_correction: mirrors the unit mask and coefficient store,
// predicts every corrected sample at request time and compares delivered results in order.
// Depends on imu_sc_pkg for widths, store layout, sensor kinds and request ops.
module imu_sc_checker
    import imu_sc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wen,
    input  logic [MASK_W-1:0]    cfg_wdata,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic                 op,
    input  logic [1:0]           sensor_kind,
    input  logic [UNIT_W-1:0]    unit,
    input  word_t                raw_x,
    input  word_t                raw_y,
    input  word_t                raw_z,
    input  word_t                temperature,
    input  logic [COEF_IX_W-1:0] coef_index,
    input  word_t                coef_value,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  word_t                cal_x,
    input  word_t                cal_y,
    input  word_t                cal_z,
    input  logic                 passed_through,
    output int                   fail_count,
    output int                   pending,
    output int                   checked
);

    // Wide enough for an exact sum of three 32x32 products
    typedef logic signed [67:0] wide_t;

    typedef struct packed {
        word_t x;
        word_t y;
        word_t z;
        logic  thru;
    } corrected_t;

    localparam wide_t SAT_HI = 68'sd2147483647;
    localparam wide_t SAT_LO = -68'sd2147483648;

    word_t             coef_mirror [NUM_UNITS][COEFS_PER_UNIT];
    logic [MASK_W-1:0] mask_mirror;
    corrected_t        corrected_q [$];
    corrected_t        want;

    // Clamp to the signed 32-bit range
    function automatic word_t clamp32(input wide_t v);
        word_t r;
        if (v > SAT_HI) begin
            r = WORD_MAX;
        end else if (v < SAT_LO) begin
            r = WORD_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Fixed-point product, floored by the fraction bits
    function automatic word_t mul_floor(input word_t a, input word_t b);
        wide_t p;
        p = wide_t'(a) * wide_t'(b);
        return clamp32(p >>> FRAC_BITS);
    endfunction

    // Expected result of one sample request against the current store and mask
    function automatic corrected_t predict_correction(input logic [1:0] kind,
                                                      input logic [UNIT_W-1:0] u,
                                                      input word_t rx,
                                                      input word_t ry,
                                                      input word_t rz,
                                                      input word_t temp);
        corrected_t r;
        word_t      raw [3];
        word_t      res [3];
        word_t      d [3];
        word_t      dt;
        word_t      tc;
        word_t      off;
        wide_t      acc;
        int         ioff;
        int         iscl;
        int         itc;
        raw[0] = rx;
        raw[1] = ry;
        raw[2] = rz;
        r.thru = 1'b0;
        if (int'(u) >= NUM_UNITS || !mask_mirror[u] || kind == KIND_NONE) begin
            // inactive unit or unknown kind: hand back the raw sample
            res = raw;
            r.thru = 1'b1;
        end else if (kind == KIND_MAG) begin
            // remove hard iron, then apply the soft-iron matrix with an exact row sum
            for (int i = 0; i < 3; i++) begin
                d[i] = clamp32(wide_t'(raw[i]) - wide_t'(coef_mirror[u][IX_MAG_OFF + i]));
            end
            for (int i = 0; i < 3; i++) begin
                acc = '0;
                for (int j = 0; j < 3; j++) begin
                    acc += wide_t'(coef_mirror[u][IX_SOFT + 3 * i + j]) * wide_t'(d[j]);
                end
                res[i] = clamp32(acc >>> FRAC_BITS);
            end
        end else begin
            // temperature correction, offset removal, scale
            ioff = (kind == KIND_ACC) ? IX_ACC_OFF : IX_GYR_OFF;
            iscl = (kind == KIND_ACC) ? IX_ACC_SCL : IX_GYR_SCL;
            itc  = (kind == KIND_ACC) ? IX_TC_ACC : IX_TC_GYR;
            dt = clamp32(wide_t'(temp) - wide_t'(coef_mirror[u][IX_TREF]));
            for (int i = 0; i < 3; i++) begin
                tc = clamp32(wide_t'(raw[i]) - wide_t'(mul_floor(dt, coef_mirror[u][itc + i])));
                off = clamp32(wide_t'(tc) - wide_t'(coef_mirror[u][ioff + i]));
                res[i] = mul_floor(off, coef_mirror[u][iscl + i]);
            end
        end
        r.x = res[0];
        r.y = res[1];
        r.z = res[2];
        return r;
    endfunction

    // Print one line per mismatch, keep counting past the print cap
    task automatic report(input string msg);
        fail_count++;
        if (fail_count <= 40) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            // reset image: unity scales, identity soft iron, zero elsewhere
            for (int u = 0; u < NUM_UNITS; u++) begin
                for (int k = 0; k < COEFS_PER_UNIT; k++) begin
                    coef_mirror[u][k] = '0;
                end
                for (int a = 0; a < 3; a++) begin
                    coef_mirror[u][IX_ACC_SCL + a] = Q_ONE;
                    coef_mirror[u][IX_GYR_SCL + a] = Q_ONE;
                    coef_mirror[u][IX_SOFT + 4 * a] = Q_ONE;
                end
            end
            mask_mirror = '0;
            corrected_q.delete();
            pending = 0;
            checked = 0;
            fail_count = 0;
        end else begin
            // track the mask
            if (cfg_wen) begin
                mask_mirror = cfg_wdata;
            end
            // apply a coefficient write, or queue the prediction for a sample
            if (in_valid && in_ready) begin
                if (op == OP_COEF) begin
                    if (int'(unit) < NUM_UNITS && int'(coef_index) < COEFS_PER_UNIT) begin
                        coef_mirror[unit][coef_index] = coef_value;
                    end
                end else begin
                    corrected_q.push_back(predict_correction(sensor_kind, unit, raw_x, raw_y,
                                                             raw_z, temperature));
                end
            end
            // compare a delivered result with the oldest prediction
            if (out_valid && out_ready) begin
                if (corrected_q.size() == 0) begin
                    report($sformatf("unexpected result %h %h %h thru=%b",
                                     cal_x, cal_y, cal_z, passed_through));
                end else begin
                    want = corrected_q.pop_front();
                    checked++;
                    if (cal_x !== want.x) begin
                        report($sformatf("cal_x got %h want %h", cal_x, want.x));
                    end
                    if (cal_y !== want.y) begin
                        report($sformatf("cal_y got %h want %h", cal_y, want.y));
                    end
                    if (cal_z !== want.z) begin
                        report($sformatf("cal_z got %h want %h", cal_z, want.z));
                    end
                    if (passed_through !== want.thru) begin
                        report($sformatf("passed_through got %b want %b",
                                         passed_through, want.thru));
                    end
                end
            end
            pending = corrected_q.size();
        end
    end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// Testbench top for imu_sample_correction: drives directed and random requests, mask
// settings and output stalls, and reports the verdict from the checker's failure count.
// Depends on imu_sc_pkg, imu_sample_correction and imu_sc_checker.
module tb_top;
    import imu_sc_pkg::*;

    typedef struct packed {
        op_t                  op;
        kind_t                kind;
        logic [UNIT_W-1:0]    unit;
        word_t                rx;
        word_t                ry;
        word_t                rz;
        word_t                temp;
        logic [COEF_IX_W-1:0] cidx;
        word_t                cval;
    } request_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wen;
    logic [MASK_W-1:0]    cfg_wdata;
    logic                 in_valid;
    logic                 in_ready;
    logic                 op;
    logic [1:0]           sensor_kind;
    logic [UNIT_W-1:0]    unit;
    word_t                raw_x;
    word_t                raw_y;
    word_t                raw_z;
    word_t                temperature;
    logic [COEF_IX_W-1:0] coef_index;
    word_t                coef_value;
    logic                 out_valid;
    logic                 out_ready;
    word_t                cal_x;
    word_t                cal_y;
    word_t                cal_z;
    logic                 passed_through;

    int fail_count;
    int pending;
    int checked;
    int sent_count;
    int mask_writes;
    bit no_idle;

    imu_sample_correction u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wen        (cfg_wen),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .sensor_kind    (sensor_kind),
        .unit           (unit),
        .raw_x          (raw_x),
        .raw_y          (raw_y),
        .raw_z          (raw_z),
        .temperature    (temperature),
        .coef_index     (coef_index),
        .coef_value     (coef_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .cal_x          (cal_x),
        .cal_y          (cal_y),
        .cal_z          (cal_z),
        .passed_through (passed_through)
    );

    imu_sc_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wen        (cfg_wen),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .sensor_kind    (sensor_kind),
        .unit           (unit),
        .raw_x          (raw_x),
        .raw_y          (raw_y),
        .raw_z          (raw_z),
        .temperature    (temperature),
        .coef_index     (coef_index),
        .coef_value     (coef_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .cal_x          (cal_x),
        .cal_y          (cal_y),
        .cal_z          (cal_z),
        .passed_through (passed_through),
        .fail_count     (fail_count),
        .pending        (pending),
        .checked        (checked)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop if the run hangs
    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Mostly extremes and small values, with full-range noise
    function automatic word_t rand_word();
        word_t w;
        case ($urandom_range(0, 9))
            0: w = WORD_MAX;
            1: w = WORD_MIN;
            2: w = word_t'($urandom_range(0, 2)) - word_t'(1);
            3, 4, 5: w = word_t'($urandom_range(0, 32'h001F_FFFF)) - word_t'(32'h0010_0000);
            default: w = $urandom;
        endcase
        return w;
    endfunction

    // Half the coefficients sit near 1.0 so corrections stay in range
    function automatic word_t rand_coef();
        word_t w;
        if ($urandom_range(0, 1) == 1) begin
            w = Q_ONE + word_t'($urandom_range(0, 32'hFFFF)) - word_t'(32'h8000);
        end else begin
            w = rand_word();
        end
        return w;
    endfunction

    // Sample request; the unused write fields carry noise
    function automatic request_t sample_req(input kind_t k, input logic [UNIT_W-1:0] u,
                                            input word_t x, input word_t y, input word_t z,
                                            input word_t t);
        request_t r;
        r.op   = OP_SAMPLE;
        r.kind = k;
        r.unit = u;
        r.rx   = x;
        r.ry   = y;
        r.rz   = z;
        r.temp = t;
        r.cidx = COEF_IX_W'($urandom_range(0, 31));
        r.cval = $urandom;
        return r;
    endfunction

    // Coefficient write request; the unused sample fields carry noise
    function automatic request_t coef_req(input logic [UNIT_W-1:0] u,
                                          input logic [COEF_IX_W-1:0] idx, input word_t v);
        request_t r;
        r = sample_req(kind_t'($urandom_range(0, 3)), u, $urandom, $urandom, $urandom,
                       $urandom);
        r.op   = OP_COEF;
        r.cidx = idx;
        r.cval = v;
        return r;
    endfunction

    function automatic request_t random_req();
        request_t r;
        kind_t    k;
        if ($urandom_range(0, 3) == 0) begin
            r = coef_req(UNIT_W'($urandom_range(0, 7)), COEF_IX_W'($urandom_range(0, 31)),
                         rand_coef());
        end else begin
            k = ($urandom_range(0, 9) == 0) ? KIND_NONE : kind_t'($urandom_range(0, 2));
            r = sample_req(k, UNIT_W'($urandom_range(0, 7)), rand_word(), rand_word(),
                           rand_word(), rand_word());
        end
        return r;
    endfunction

    // Idle a random gap, present the request and hold it until accepted
    task automatic send_req(input request_t r);
        int   gap;
        logic rdy;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        op          <= r.op;
        sensor_kind <= r.kind;
        unit        <= r.unit;
        raw_x       <= r.rx;
        raw_y       <= r.ry;
        raw_z       <= r.rz;
        temperature <= r.temp;
        coef_index  <= r.cidx;
        coef_value  <= r.cval;
        in_valid    <= 1'b1;
        do begin
            @(negedge clk);
            rdy = in_ready;
            @(posedge clk);
        end while (!rdy);
        sent_count++;
    endtask

    // Drop valid, drain all results, then let the pipeline settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_mask(input logic [MASK_W-1:0] v);
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_wen   <= 1'b0;
        mask_writes++;
    endtask

    // Output side: stall a random number of cycles before each result
    initial
    begin
        int   stall;
        logic vld;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do begin
                @(negedge clk);
                vld = out_valid;
                @(posedge clk);
            end while (!vld);
        end
    end

    // Stimulus
    initial
    begin
        logic [MASK_W-1:0] mask_plan [8];
        logic [MASK_W-1:0] m;
        mask_plan = '{8'h00, 8'hFF, 8'hA5, 8'h00, 8'h5A, 8'h01, 8'h80, 8'hFF};
        rst_n       = 1'b0;
        cfg_wen     = 1'b0;
        cfg_wdata   = '0;
        in_valid    = 1'b0;
        op          = 1'b0;
        sensor_kind = '0;
        unit        = '0;
        raw_x       = '0;
        raw_y       = '0;
        raw_z       = '0;
        temperature = '0;
        coef_index  = '0;
        coef_value  = '0;
        sent_count  = 0;
        mask_writes = 0;
        no_idle     = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // mask still clear after reset: sample comes back raw
        send_req(sample_req(KIND_ACC, 3'd0, WORD_MAX, WORD_MIN, 0, WORD_MAX));
        wait_idle();
        write_mask(8'hFF);

        // reset coefficients on every kind, extreme samples and temperatures
        send_req(sample_req(KIND_ACC, 3'd1, WORD_MAX, WORD_MIN, -1, WORD_MIN));
        send_req(sample_req(KIND_GYR, 3'd2, WORD_MIN, WORD_MAX, 1, WORD_MAX));
        send_req(sample_req(KIND_MAG, 3'd3, WORD_MAX, WORD_MIN, Q_ONE, 0));
        // unknown kind passes through even on an active unit
        send_req(sample_req(KIND_NONE, 3'd4, 123, -456, WORD_MAX, 0));

        // saturate every accelerometer stage
        send_req(coef_req(3'd5, COEF_IX_W'(IX_ACC_SCL), WORD_MAX));
        send_req(coef_req(3'd5, COEF_IX_W'(IX_ACC_OFF + 1), WORD_MIN));
        send_req(coef_req(3'd5, COEF_IX_W'(IX_TREF), WORD_MAX));
        send_req(coef_req(3'd5, COEF_IX_W'(IX_TC_ACC + 2), WORD_MIN));
        send_req(sample_req(KIND_ACC, 3'd5, WORD_MAX, WORD_MAX, WORD_MIN, WORD_MIN));

        // write past the last coefficient index: dropped
        send_req(coef_req(3'd5, COEF_IX_W'(COEFS_PER_UNIT), WORD_MAX));
        send_req(sample_req(KIND_ACC, 3'd5, 1, -1, 0, 0));

        // hard-iron offset saturates the difference, large soft-iron term
        send_req(coef_req(3'd5, COEF_IX_W'(IX_MAG_OFF), WORD_MIN));
        send_req(coef_req(3'd5, COEF_IX_W'(IX_SOFT + 1), WORD_MAX));
        send_req(sample_req(KIND_MAG, 3'd5, WORD_MAX, WORD_MIN, WORD_MAX, 0));

        // negative scale and half-unit temperature slope: floor rounding
        send_req(coef_req(3'd6, COEF_IX_W'(IX_GYR_SCL), -Q_ONE));
        send_req(coef_req(3'd6, COEF_IX_W'(IX_TC_GYR), 32'sh0000_8000));
        send_req(sample_req(KIND_GYR, 3'd6, -1, 3, WORD_MIN, 32'sh0003_0001));
        send_req(sample_req(KIND_MAG, 3'd7, -1, -1, -1, 0));

        // random phases, each under its own mask
        for (int p = 0; p < 8; p++) begin
            wait_idle();
            m = (p == 3 || p == 6) ? 8'($urandom_range(0, 255)) : mask_plan[p];
            write_mask(m);
            no_idle = (p == 2 || p == 5);
            for (int n = 0; n < 250; n++) begin
                send_req(random_req());
            end
        end
        no_idle = 1'b0;

        wait_idle();
        repeat (10) @(posedge clk);
        $display("covered %0d requests (%0d corrected samples checked) over %0d mask settings",
                 sent_count, checked, mask_writes);
        $display("failures: %0d", fail_count);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
src/imu_sc_pkg.sv
src/imu_sc_coef_store.sv
src/imu_sc_pipe_ctrl.sv
src/imu_sc_datapath.sv
src/imu_sample_correction.sv
test/imu_sc_checker.sv
test/tb_top.sv
